/* sv/segment_partition_dp_defines.svh */
// Assertion macros shared by the segment partition RTL.
`ifndef SEGMENT_PARTITION_DP_DEFINES_SVH
`define SEGMENT_PARTITION_DP_DEFINES_SVH

// Clocked check, switched off while reset is asserted.
`define SPDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication check built on the one above.
`define SPDP_ASSERT_IMPL(lbl, pre, post, msg) \
  `SPDP_ASSERT(lbl, (pre) |-> (post), msg)

`endif

/* sv/spdp_pkg.sv */
// Package: sizes, codes and types of the segment partition block.
package spdp_pkg;

  localparam int unsigned MAX_ITEMS   = 64;
  localparam int unsigned MAX_GROUPS  = 64;

  localparam int unsigned CFG_W       = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned ENTRY_W     = 8;
  localparam int unsigned DP_W        = 30;

  localparam int unsigned N_W         = $clog2(MAX_ITEMS + 2);
  localparam int unsigned IDX_W       = $clog2(MAX_ITEMS);
  localparam int unsigned MAT_DEPTH   = MAX_ITEMS * MAX_ITEMS;
  localparam int unsigned MAT_AW      = 2 * IDX_W;
  localparam int unsigned PSUM_W      = $clog2(MAX_ITEMS * 255 + 1);
  localparam int unsigned COST_W      = $clog2(MAX_ITEMS * MAX_ITEMS * 255 + 1);
  localparam int unsigned DP_DEPTH    = MAX_ITEMS + 1;
  localparam int unsigned DP_AW       = $clog2(MAX_ITEMS + 1);
  localparam int unsigned STACK_DEPTH = 2 * N_W + 4;
  localparam int unsigned STK_AW      = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);

  localparam logic [DP_W-1:0] COST_INF = DP_W'(1000000000);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ITEMS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_GROUPS = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BROW,
    ST_BRDD,
    ST_BRDO,
    ST_BWR,
    ST_INIT,
    ST_DPOP,
    ST_DADDR,
    ST_DCMP,
    ST_DWR,
    ST_LEND,
    ST_RADDR,
    ST_RDATA
  } spdp_state_e;

  // One pending range of the split search
  typedef struct packed {
    logic [N_W-1:0] lo;
    logic [N_W-1:0] hi;
    logic [N_W-1:0] olo;
    logic [N_W-1:0] ohi;
  } spdp_range_t;

endpackage

/* sv/spdp_ram.sv */
// Generic simple dual-port RAM with registered read data.
module spdp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/segment_partition_dp.sv */
// Usage: the cfg channel writes num_items (index 0) and num_groups (index 1);
// any other index is ignored. cfg_ready_o is always high. Writing num_items
// restarts the matrix load. Configuration is to be written only while idle;
// the block itself does not enforce it. The input channel takes one matrix
// entry per transaction, row-major, one per cycle while in_ready_o is high.
// After the last of n*n entries the block solves: it builds the segment
// cost table (two reads of the prefix RAM per cost), fills the first layer,
// then runs k layers of the split search, each candidate using an address
// and a compare state on the shared add/compare unit, and reads the answer
// (with k = 0 it reports infeasible). in_ready_o is low throughout the solve.
// One result transaction (min_cost, feasible) follows each full matrix. The
// result sits in an output register; loading of the next matrix goes on
// while it waits, but its last entry is held off until the result is taken.
// Reset: num_items = 1, num_groups = 1, load position cleared, output empty.
// No memory is cleared; every entry is written before it is read.
module segment_partition_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [spdp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [spdp_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [spdp_pkg::ENTRY_W-1:0]     entry_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [spdp_pkg::DP_W-1:0]        min_cost_o,
  output logic                             feasible_o
);
  import spdp_pkg::*;
  `include "segment_partition_dp_defines.svh"

  spdp_state_e state_q, state_d;

  logic [CFG_W-1:0]  num_items_q, num_groups_q;
  logic [N_W-1:0]    n_eff;
  logic [N_W-1:0]    row_q, col_q;
  logic [PSUM_W-1:0] run_q, psum;
  logic              in_acc, last_entry;

  logic [N_W-1:0]    bi_q, bj_q, bi_m1, bi_m2, bj_m1;
  logic [COST_W-1:0] acc_q, cost_new;
  logic [PSUM_W-1:0] diag_q, off_val;

  logic [N_W-1:0]    init_q;
  logic              sel_q;
  logic [CFG_W-1:0]  layer_q;
  logic [SP_W-1:0]   sp_q, sp_m1, sp_p1;
  spdp_range_t       stk_q [STACK_DEPTH];
  spdp_range_t       tos, root;
  logic [N_W-1:0]    lo_q, hi_q, olo_q, ohi_q, mid_q, top_q, c_q, opt_q;
  logic [DP_W-1:0]   best_q;
  logic [N_W:0]      mid_sum;
  logic [N_W-1:0]    mid_c, mid_m1_c, top_c, mid_m1;
  logic              no_cand;
  logic [DP_W:0]     cand_sum;

  logic              out_valid_q, feasible_q;
  logic [DP_W-1:0]   min_cost_q;

  // memory ports
  logic              pre_we, cost_we, dp0_we, dp1_we;
  logic [MAT_AW-1:0] pre_waddr, pre_raddr, cost_waddr, cost_raddr;
  logic [PSUM_W-1:0] pre_rd;
  logic [COST_W-1:0] cost_wdata, cost_rd;
  logic [DP_AW-1:0]  dp_waddr, dp_raddr;
  logic [DP_W-1:0]   dp_wdata, dp0_rd, dp1_rd, prev_rd;

  // effective item count
  always_comb begin
    if (num_items_q == '0) begin
      n_eff = N_W'(1);
    end else if (int'(num_items_q) > MAX_ITEMS) begin
      n_eff = N_W'(MAX_ITEMS);
    end else begin
      n_eff = N_W'(num_items_q);
    end
  end

  // load side
  assign last_entry = (row_q == n_eff - N_W'(1)) && (col_q == n_eff - N_W'(1));
  assign in_ready_o = (state_q == ST_LOAD) && !(last_entry && out_valid_q);
  assign in_acc     = in_valid_i && in_ready_o;
  assign psum       = ((col_q == '0) ? '0 : run_q) + PSUM_W'(entry_value_i);
  assign cfg_ready_o = 1'b1;

  // cost build helpers
  assign bi_m1    = bi_q - N_W'(1);
  assign bi_m2    = bi_q - N_W'(2);
  assign bj_m1    = bj_q - N_W'(1);
  assign off_val  = (bi_q == N_W'(1)) ? '0 : pre_rd;
  assign cost_new = acc_q + COST_W'(diag_q) - COST_W'(off_val);

  // split search helpers
  assign sp_m1    = sp_q - SP_W'(1);
  assign sp_p1    = sp_q + SP_W'(1);
  assign tos      = stk_q[sp_m1[STK_AW-1:0]];
  assign root     = '{lo: '0, hi: n_eff, olo: '0, ohi: n_eff};
  assign mid_sum  = {1'b0, tos.lo} + {1'b0, tos.hi};
  assign mid_c    = mid_sum[N_W:1];
  assign mid_m1_c = mid_c - N_W'(1);
  assign top_c    = (tos.ohi < mid_m1_c) ? tos.ohi : mid_m1_c;
  assign no_cand  = (mid_c == '0) || (tos.olo > top_c);
  assign mid_m1   = mid_q - N_W'(1);
  assign prev_rd  = sel_q ? dp1_rd : dp0_rd;
  assign cand_sum = {1'b0, prev_rd} + (DP_W + 1)'(cost_rd);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_acc && last_entry) state_d = ST_BROW;
      ST_BROW:  state_d = (bi_q == n_eff) ? ST_INIT : ST_BRDD;
      ST_BRDD:  state_d = ST_BRDO;
      ST_BRDO:  state_d = ST_BWR;
      ST_BWR:   state_d = (bj_q == n_eff) ? ST_BROW : ST_BRDD;
      ST_INIT: begin
        if (init_q == n_eff) state_d = (num_groups_q == '0) ? ST_LOAD : ST_DPOP;
      end
      ST_DPOP: begin
        priority if (sp_q == '0) state_d = ST_LEND;
        else if (tos.lo > tos.hi) state_d = ST_DPOP;
        else if (no_cand) state_d = ST_DWR;
        else state_d = ST_DADDR;
      end
      ST_DADDR: state_d = ST_DCMP;
      ST_DCMP:  state_d = (c_q == top_q) ? ST_DWR : ST_DADDR;
      ST_DWR:   state_d = ST_DPOP;
      ST_LEND:  state_d = (layer_q == num_groups_q) ? ST_RADDR : ST_DPOP;
      ST_RADDR: state_d = ST_RDATA;
      ST_RDATA: state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  // memory controls
  always_comb begin
    pre_we     = in_acc;
    pre_waddr  = {row_q[IDX_W-1:0], col_q[IDX_W-1:0]};
    pre_raddr  = (state_q == ST_BRDO) ? {bj_m1[IDX_W-1:0], bi_m2[IDX_W-1:0]}
                                      : {bj_m1[IDX_W-1:0], bj_m1[IDX_W-1:0]};
    cost_we    = (state_q == ST_BROW) || (state_q == ST_BWR);
    cost_waddr = (state_q == ST_BROW) ? {bi_m1[IDX_W-1:0], bi_m1[IDX_W-1:0]}
                                      : {bi_m1[IDX_W-1:0], bj_m1[IDX_W-1:0]};
    cost_wdata = (state_q == ST_BROW) ? '0 : cost_new;
    cost_raddr = {c_q[IDX_W-1:0], mid_m1[IDX_W-1:0]};
    // previous layer is the RAM picked by sel_q, current the other
    dp0_we     = ((state_q == ST_INIT) && !sel_q) || ((state_q == ST_DWR) && sel_q);
    dp1_we     = ((state_q == ST_INIT) && sel_q) || ((state_q == ST_DWR) && !sel_q);
    dp_waddr   = (state_q == ST_INIT) ? init_q[DP_AW-1:0] : mid_q[DP_AW-1:0];
    if (state_q == ST_INIT) begin
      dp_wdata = (init_q == '0) ? '0 : COST_INF;
    end else begin
      dp_wdata = best_q;
    end
    dp_raddr   = (state_q == ST_RADDR) ? n_eff[DP_AW-1:0] : c_q[DP_AW-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      num_items_q  <= CFG_W'(1);
      num_groups_q <= CFG_W'(1);
      row_q        <= '0;
      col_q        <= '0;
      sp_q         <= '0;
      sel_q        <= 1'b0;
      layer_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // configuration writes
      if (cfg_valid_i && (cfg_index_i == CFG_NUM_ITEMS)) begin
        num_items_q <= cfg_data_i;
        row_q       <= '0;
        col_q       <= '0;
      end else if (cfg_valid_i && (cfg_index_i == CFG_NUM_GROUPS)) begin
        num_groups_q <= cfg_data_i;
      end
      // load position
      if (in_acc) begin
        if (col_q == n_eff - N_W'(1)) begin
          col_q <= '0;
          row_q <= (row_q == n_eff - N_W'(1)) ? '0 : row_q + N_W'(1);
        end else begin
          col_q <= col_q + N_W'(1);
        end
      end
      // stack pointer and layer
      unique case (state_q)
        ST_INIT: begin
          if ((init_q == n_eff) && (num_groups_q != '0)) begin
            sp_q    <= SP_W'(1);
            layer_q <= CFG_W'(1);
          end
        end
        ST_DPOP: if (sp_q != '0) sp_q <= sp_m1;
        ST_DWR:  sp_q <= (mid_q != '0) ? sp_q + SP_W'(2) : sp_p1;
        ST_LEND: begin
          sel_q <= ~sel_q;
          if (layer_q != num_groups_q) begin
            layer_q <= layer_q + CFG_W'(1);
            sp_q    <= SP_W'(1);
          end
        end
        default: ;
      endcase
      // result register
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end else if ((state_q == ST_RDATA) ||
                   ((state_q == ST_INIT) && (init_q == n_eff) && (num_groups_q == '0))) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) run_q <= psum;
    unique case (state_q)
      ST_LOAD: begin
        bi_q <= N_W'(1);
      end
      ST_BROW: begin
        bj_q   <= bi_q + N_W'(1);
        acc_q  <= '0;
        init_q <= '0;
      end
      ST_BRDO: diag_q <= pre_rd;
      ST_BWR: begin
        acc_q <= cost_new;
        if (bj_q == n_eff) bi_q <= bi_q + N_W'(1);
        else bj_q <= bj_q + N_W'(1);
      end
      ST_INIT: begin
        init_q <= init_q + N_W'(1);
        if (init_q == n_eff) begin
          stk_q[0]   <= root;
          min_cost_q <= COST_INF;
          feasible_q <= 1'b0;
        end
      end
      ST_DPOP: begin
        lo_q   <= tos.lo;
        hi_q   <= tos.hi;
        olo_q  <= tos.olo;
        ohi_q  <= tos.ohi;
        mid_q  <= mid_c;
        top_q  <= top_c;
        c_q    <= tos.olo;
        opt_q  <= tos.olo;
        best_q <= COST_INF;
      end
      ST_DCMP: begin
        // shared add and compare: strict less-than keeps the lowest split
        if (cand_sum < {1'b0, best_q}) begin
          best_q <= cand_sum[DP_W-1:0];
          opt_q  <= c_q;
        end
        c_q <= c_q + N_W'(1);
      end
      ST_DWR: begin
        if (mid_q != '0) begin
          stk_q[sp_q[STK_AW-1:0]]  <= '{lo: lo_q, hi: mid_m1, olo: olo_q, ohi: opt_q};
          stk_q[sp_p1[STK_AW-1:0]] <= '{lo: mid_q + N_W'(1), hi: hi_q, olo: opt_q,
                                        ohi: ohi_q};
        end else begin
          stk_q[sp_q[STK_AW-1:0]]  <= '{lo: mid_q + N_W'(1), hi: hi_q, olo: opt_q,
                                        ohi: ohi_q};
        end
      end
      ST_LEND: if (layer_q != num_groups_q) stk_q[0] <= root;
      ST_RDATA: begin
        min_cost_q <= prev_rd;
        feasible_q <= (prev_rd < COST_INF);
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign min_cost_o  = min_cost_q;
  assign feasible_o  = feasible_q;

  // row prefix sums
  spdp_ram #(.Width(PSUM_W), .Depth(MAT_DEPTH)) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (pre_we),
    .waddr_i (pre_waddr),
    .wdata_i (psum),
    .raddr_i (pre_raddr),
    .rdata_o (pre_rd)
  );

  // segment cost table
  spdp_ram #(.Width(COST_W), .Depth(MAT_DEPTH)) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (cost_we),
    .waddr_i (cost_waddr),
    .wdata_i (cost_wdata),
    .raddr_i (cost_raddr),
    .rdata_o (cost_rd)
  );

  // ping-pong DP layers
  spdp_ram #(.Width(DP_W), .Depth(DP_DEPTH)) u_layer0_ram (
    .clk_i   (clk_i),
    .we_i    (dp0_we),
    .waddr_i (dp_waddr),
    .wdata_i (dp_wdata),
    .raddr_i (dp_raddr),
    .rdata_o (dp0_rd)
  );

  spdp_ram #(.Width(DP_W), .Depth(DP_DEPTH)) u_layer1_ram (
    .clk_i   (clk_i),
    .we_i    (dp1_we),
    .waddr_i (dp_waddr),
    .wdata_i (dp_wdata),
    .raddr_i (dp_raddr),
    .rdata_o (dp1_rd)
  );

  // checks
  `SPDP_ASSERT_IMPL(a_ready_load, in_ready_o, state_q == ST_LOAD, "ready outside load")
  `SPDP_ASSERT(a_stack_bound, sp_q <= SP_W'(STACK_DEPTH), "range stack overflow")
  `SPDP_ASSERT_IMPL(a_feasible, out_valid_o, feasible_o == (min_cost_o != COST_INF), "flag mismatch")
  `SPDP_ASSERT(a_solve_start, (in_acc && last_entry) |=> (state_q == ST_BROW), "solve not started")

endmodule
